/* hw/rtl/bfwe_pkg.sv */
// ----------------------------------------------------------------------------
// bfwe_pkg
// Shared constants and character-set helpers for the word enumerator.
// ----------------------------------------------------------------------------
package bfwe_pkg;

  localparam int unsigned DIGIT_W   = 7;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned MAXLEN_W  = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHARSET_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 1'd1;

  // character group bits
  localparam logic [MASK_W-1:0] GRP_UPPER  = 4'h1;
  localparam logic [MASK_W-1:0] GRP_LOWER  = 4'h2;
  localparam logic [MASK_W-1:0] GRP_DIGIT  = 4'h4;
  localparam logic [MASK_W-1:0] GRP_SYMBOL = 4'h8;

  localparam logic [MASK_W-1:0] CHARSET_RESET = 4'd5;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 5'd1;

  localparam logic [CHAR_W-1:0] SYMBOL_CHARS [10] = '{
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28, 8'h29
  };

  function automatic logic [MASK_W-1:0] eff_mask(input logic [MASK_W-1:0] m);
    return (m == '0) ? (GRP_UPPER | GRP_DIGIT) : m;
  endfunction

  function automatic logic [DIGIT_W-1:0] set_size(input logic [MASK_W-1:0] m);
    logic [DIGIT_W-1:0] n;
    n = '0;
    if ((m & GRP_UPPER) != '0)  n = n + 7'd26;
    if ((m & GRP_LOWER) != '0)  n = n + 7'd26;
    if ((m & GRP_DIGIT) != '0)  n = n + 7'd10;
    if ((m & GRP_SYMBOL) != '0) n = n + 7'd10;
    return n;
  endfunction

  // character at index k of the set, k below the set size
  function automatic logic [CHAR_W-1:0] char_at(input logic [MASK_W-1:0] m,
                                                input logic [DIGIT_W-1:0] k_in);
    logic [DIGIT_W-1:0] k;
    logic [CHAR_W-1:0]  c;
    logic               hit;
    k   = k_in;
    c   = '0;
    hit = 1'b0;
    if ((m & GRP_UPPER) != '0) begin
      if (k < 7'd26) begin
        c   = 8'h41 + CHAR_W'(k);
        hit = 1'b1;
      end else begin
        k = k - 7'd26;
      end
    end
    if (!hit && (m & GRP_LOWER) != '0) begin
      if (k < 7'd26) begin
        c   = 8'h61 + CHAR_W'(k);
        hit = 1'b1;
      end else begin
        k = k - 7'd26;
      end
    end
    if (!hit && (m & GRP_DIGIT) != '0) begin
      if (k < 7'd10) begin
        c   = 8'h30 + CHAR_W'(k);
        hit = 1'b1;
      end else begin
        k = k - 7'd10;
      end
    end
    if (!hit && k < 7'd10) begin
      c = SYMBOL_CHARS[k[3:0]];
    end
    return c;
  endfunction

endpackage

/* hw/rtl/bfwe_in_if.sv */
// ----------------------------------------------------------------------------
// bfwe_in_if
// Command channel of the word enumerator: valid, ready and the restart flag.
// ----------------------------------------------------------------------------
interface bfwe_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

/* hw/rtl/bfwe_out_if.sv */
// ----------------------------------------------------------------------------
// bfwe_out_if
// Character channel of the word enumerator: one character per beat.
// ----------------------------------------------------------------------------
interface bfwe_out_if import bfwe_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic [POS_W-1:0]  char_position;
  logic              word_end;
  logic              done_res;

  modport source (output valid, output char_code, output char_position,
                  output word_end, output done_res, input ready);
  modport sink   (input valid, input char_code, input char_position,
                  input word_end, input done_res, output ready);
endinterface

/* hw/rtl/brute_force_word_enumerator.sv */
// ----------------------------------------------------------------------------
// brute_force_word_enumerator
// Lists all words over a selectable character set, length 1 up to a limit.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : command beats; restart=1 rewinds to the first one-letter word and
//            gives no output, restart=0 emits the current word and advances.
//   out_o  : one beat per character, leftmost first, with its position,
//            word_end on the last character and done_res on the last
//            character of the final word. After that, advance beats give
//            nothing until a restart.
//   cfg_*  : write charset_mask (index 0) and max_length (index 1) while idle.
// Timing: a command is taken only in the idle state. A word is emitted one
//   character per cycle through the single digit read port while the output
//   slot is free, then the odometer carry ripples leftward from the rightmost
//   digit with the shared increment unit. After a command is taken the
//   sequencer enters the emit state, and the first character is then loaded
//   into the output register for out_o. A stalled receiver holds the output
//   register and the sequencer waits. Reset clears the odometer, sets length
//   one and loads charset_mask=5, max_length=1.
// ----------------------------------------------------------------------------
module brute_force_word_enumerator import bfwe_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  bfwe_in_if.sink              in_i,
  bfwe_out_if.source           out_o
);

  localparam int unsigned IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned LIM_W = 6;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  logic [1:0]          state_q;
  logic [MASK_W-1:0]   mask_q;
  logic [MAXLEN_W-1:0] maxlen_q;
  logic [DIGIT_W-1:0]  digits_q [MAX_LENGTH];
  logic [LEN_W-1:0]    cur_len_q;
  logic                finished_q;
  logic [IDX_W-1:0]    ptr_q;
  logic                all_top_q;
  logic                out_valid_q;
  logic [CHAR_W-1:0]   char_q;
  logic [POS_W-1:0]    pos_q;
  logic                end_q;
  logic                done_q;

  logic [MASK_W-1:0]   m;
  logic [DIGIT_W-1:0]  size;
  logic [DIGIT_W-1:0]  top;
  logic [LIM_W-1:0]    lim;
  logic [DIGIT_W-1:0]  dig;
  logic [DIGIT_W-1:0]  dig_clip;
  logic [DIGIT_W:0]    dig_inc;
  logic                slot_free;
  logic                emit_beat;
  logic                last_pos;
  logic                all_top_d;
  logic                is_final;
  logic                in_fire;

  always_comb begin
    m    = eff_mask(mask_q);
    size = set_size(m);
    top  = size - 7'd1;
    lim  = LIM_W'(maxlen_q);
    if (lim == '0) lim = LIM_W'(1);
    if (lim > LIM_W'(MAX_LENGTH)) lim = LIM_W'(MAX_LENGTH);
  end

  // single read port into the digit registers
  assign dig       = digits_q[ptr_q];
  assign dig_clip  = (dig > top) ? top : dig;
  assign dig_inc   = {1'b0, dig} + 8'd1;
  assign slot_free = !out_valid_q || out_o.ready;
  assign emit_beat = (state_q == ST_EMIT) && slot_free;
  assign last_pos  = (LEN_W'(ptr_q) + LEN_W'(1)) == cur_len_q;
  assign all_top_d = all_top_q && (dig >= top);
  assign is_final  = all_top_d && (LIM_W'(cur_len_q) >= lim);
  assign in_fire   = in_i.valid && in_i.ready;

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.char_code     = char_q;
  assign out_o.char_position = pos_q;
  assign out_o.word_end      = end_q;
  assign out_o.done_res      = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= CHARSET_RESET;
      maxlen_q    <= MAXLEN_RESET;
      cur_len_q   <= LEN_W'(1);
      finished_q  <= 1'b0;
      ptr_q       <= '0;
      all_top_q   <= 1'b1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_LENGTH; i++) digits_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CHARSET_MASK: mask_q   <= cfg_data_i[MASK_W-1:0];
          REG_MAX_LENGTH:   maxlen_q <= cfg_data_i[MAXLEN_W-1:0];
          default: ;
        endcase
      end

      if (emit_beat) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_i.restart) begin
              for (int i = 0; i < MAX_LENGTH; i++) digits_q[i] <= '0;
              cur_len_q  <= LEN_W'(1);
              finished_q <= 1'b0;
            end else if (!finished_q) begin
              ptr_q     <= '0;
              all_top_q <= 1'b1;
              state_q   <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            all_top_q <= all_top_d;
            if (last_pos) begin
              if (is_final) begin
                finished_q <= 1'b1;
                state_q    <= ST_IDLE;
              end else if (all_top_d) begin
                for (int i = 0; i < MAX_LENGTH; i++) digits_q[i] <= '0;
                cur_len_q <= cur_len_q + LEN_W'(1);
                state_q   <= ST_IDLE;
              end else begin
                // carry ripples leftward starting at the rightmost digit
                state_q <= ST_STEP;
              end
            end else begin
              ptr_q <= ptr_q + IDX_W'(1);
            end
          end
        end
        ST_STEP: begin
          if (dig_inc >= {1'b0, size}) begin
            digits_q[ptr_q] <= '0;
            ptr_q           <= ptr_q - IDX_W'(1);
          end else begin
            digits_q[ptr_q] <= dig_inc[DIGIT_W-1:0];
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output payload, loaded with each character beat
  always_ff @(posedge clk_i) begin
    if (emit_beat) begin
      char_q <= char_at(m, dig_clip);
      pos_q  <= POS_W'(ptr_q);
      end_q  <= last_pos;
      done_q <= last_pos && is_final;
    end
  end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for brute_force_word_enumerator: command beats are
// mirrored into a behavioral odometer that predicts every character beat,
// and each beat leaving the block is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import bfwe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_MAX      = 16;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned SETTLE_CYCLES = 2 * WORD_MAX + 8;
  localparam int unsigned STALL_LIMIT   = 5000;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic [POS_W-1:0]  pos;
    logic              word_end;
    logic              done_flag;
  } char_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;

  bfwe_in_if  cmd_if ();
  bfwe_out_if char_if ();

  brute_force_word_enumerator u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (char_if)
  );

  // predictor state
  logic [DIGIT_W-1:0]  odo [WORD_MAX];
  int unsigned         word_len;
  bit                  enum_done;
  logic [MASK_W-1:0]   set_mask;
  logic [MAXLEN_W-1:0] len_cap;

  char_beat_t  pending_chars [$];
  int unsigned err_count;
  int unsigned live_items;
  int unsigned stall_cycles;
  bit          steady;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string charset_string(input logic [MASK_W-1:0] m);
    string             s;
    logic [MASK_W-1:0] em;
    s  = "";
    em = (m == '0) ? (GRP_UPPER | GRP_DIGIT) : m;
    if ((em & GRP_UPPER) != '0)  s = {s, "ABCDEFGHIJKLMNOPQRSTUVWXYZ"};
    if ((em & GRP_LOWER) != '0)  s = {s, "abcdefghijklmnopqrstuvwxyz"};
    if ((em & GRP_DIGIT) != '0)  s = {s, "0123456789"};
    if ((em & GRP_SYMBOL) != '0) s = {s, "!@#$%^&*()"};
    return s;
  endfunction

  // applies one command to the odometer and queues the characters it emits;
  // returns 0 when the command is ignored
  function automatic bit step_enumerator(input logic restart);
    string       alpha;
    int unsigned n, top, lim, d;
    int          i;
    bit          at_top, final_word;
    char_beat_t  beat;
    if (restart) begin
      foreach (odo[j]) odo[j] = '0;
      word_len  = 1;
      enum_done = 1'b0;
      return 1'b1;
    end
    if (enum_done) return 1'b0;
    alpha = charset_string(set_mask);
    n     = alpha.len();
    top   = n - 1;
    lim   = (len_cap == '0) ? 1 : ((len_cap > WORD_MAX) ? WORD_MAX : len_cap);
    at_top = 1'b1;
    for (i = 0; i < word_len; i++) begin
      if (odo[i] < top) at_top = 1'b0;
    end
    final_word = at_top && (word_len >= lim);
    for (i = 0; i < word_len; i++) begin
      // digits left over from a bigger set show as its last character
      d              = (odo[i] > top) ? top : odo[i];
      beat.code      = alpha[d];
      beat.pos       = POS_W'(i);
      beat.word_end  = (i == word_len - 1);
      beat.done_flag = (i == word_len - 1) && final_word;
      pending_chars.push_back(beat);
    end
    if (final_word) begin
      enum_done = 1'b1;
    end else if (at_top) begin
      foreach (odo[j]) odo[j] = '0;
      word_len = word_len + 1;
    end else begin
      for (i = word_len - 1; i >= 0; i--) begin
        if (odo[i] + 1 >= n) begin
          odo[i] = '0;
        end else begin
          odo[i] = odo[i] + 1'b1;
          break;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("error: %s", msg);
  endfunction

  // character beats: compare, then pick the next ready level
  always @(posedge clk) begin
    char_beat_t want, got;
    if (char_if.valid && char_if.ready) begin
      got = '{char_if.char_code, char_if.char_position, char_if.word_end, char_if.done_res};
      if (pending_chars.size() == 0) begin
        note_error($sformatf("unexpected beat code %h pos %0d end %b done %b",
                             got.code, got.pos, got.word_end, got.done_flag));
      end else begin
        want = pending_chars.pop_front();
        if (got.code !== want.code || got.pos !== want.pos ||
            got.word_end !== want.word_end || got.done_flag !== want.done_flag) begin
          note_error($sformatf({"expected code %h pos %0d end %b done %b, ",
                                "got code %h pos %0d end %b done %b"},
                               want.code, want.pos, want.word_end, want.done_flag,
                               got.code, got.pos, got.word_end, got.done_flag));
        end
      end
    end
    char_if.ready <= steady || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (char_if.valid && char_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("error: no beat accepted for %0d cycles", stall_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_cmd(input logic restart);
    while (!steady && $urandom_range(99) < 20) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.restart <= restart;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    if (step_enumerator(restart)) live_items++;
  endtask

  task automatic drain_chars();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // idle with no characters owed, and the odometer carry has finished
  task automatic settle();
    drain_chars();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DAT_W-1:0] mask_data,
                            input logic [CFG_DAT_W-1:0] len_data);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_CHARSET_MASK;
    cfg_data <= mask_data;
    @(posedge clk);
    cfg_idx  <= REG_MAX_LENGTH;
    cfg_data <= len_data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    set_mask = mask_data[MASK_W-1:0];
    len_cap  = len_data[MAXLEN_W-1:0];
  endtask

  task automatic test_reset_defaults();
    send_cmd(1'b0);
    send_cmd(1'b0);
    settle();
  endtask

  // symbols only, max length zero acting as one, run to the final word
  task automatic test_symbols_to_done();
    set_config(CFG_DAT_W'(GRP_SYMBOL), 5'd0);
    while (!enum_done) send_cmd(1'b0);
    send_cmd(1'b0);
    settle();
  endtask

  // digits beyond a shrunk set clamp to its last character, and a lowered
  // length limit makes the current word the final one
  task automatic test_shrunk_charset();
    set_config(CFG_DAT_W'(GRP_LOWER), 5'd2);
    send_cmd(1'b1);
    repeat (10) send_cmd(1'b0);
    settle();
    set_config(5'h14, 5'd1);
    send_cmd(1'b0);
    settle();
  endtask

  task automatic test_config_extremes();
    set_config(5'h00, 5'd31);
    send_cmd(1'b1);
    send_cmd(1'b0);
    send_cmd(1'b0);
    settle();
    set_config(5'h0f, 5'd16);
    send_cmd(1'b0);
    send_cmd(1'b0);
    settle();
  endtask

  task automatic test_random_runs();
    int unsigned          goal;
    int unsigned          n_items;
    logic [CFG_DAT_W-1:0] mask_data, len_data;
    bit                   full_run;
    goal = live_items + RANDOM_ITEMS;
    while (live_items < goal) begin
      steady   = (live_items + RANDOM_ITEMS < goal + 60);
      full_run = ($urandom_range(99) < 25);
      if (full_run) begin
        // ten-character sets keep a complete run short
        mask_data = {1'($urandom_range(1)), ($urandom_range(1) != 0) ? GRP_DIGIT : GRP_SYMBOL};
        len_data  = CFG_DAT_W'($urandom_range(2));
      end else begin
        mask_data = CFG_DAT_W'($urandom_range(31));
        case ($urandom_range(9))
          0:       len_data = 5'd0;
          1:       len_data = CFG_DAT_W'($urandom_range(16, 31));
          default: len_data = CFG_DAT_W'($urandom_range(1, 3));
        endcase
      end
      settle();
      set_config(mask_data, len_data);
      if (full_run || $urandom_range(99) < 40) send_cmd(1'b1);
      if (full_run) begin
        while (!enum_done) send_cmd(1'b0);
        send_cmd(1'b0);
      end else begin
        n_items = $urandom_range(5, 30);
        repeat (n_items) begin
          if (enum_done && $urandom_range(1) != 0) send_cmd(1'b1);
          else send_cmd($urandom_range(99) < 5);
          if ($urandom_range(99) < 3) drain_chars();
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.restart = 1'b0;
    char_if.ready  = 1'b0;
    steady         = 1'b0;
    err_count      = 0;
    live_items     = 0;
    stall_cycles   = 0;
    foreach (odo[j]) odo[j] = '0;
    word_len       = 1;
    enum_done      = 1'b0;
    set_mask       = CHARSET_RESET;
    len_cap        = MAXLEN_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_symbols_to_done();
    test_shrunk_charset();
    test_config_extremes();
    test_random_runs();
    settle();

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bfwe_pkg.sv
hw/rtl/bfwe_in_if.sv
hw/rtl/bfwe_out_if.sv
hw/rtl/brute_force_word_enumerator.sv
sim/tb.sv
